FILE: src/lsc_pkg.sv
// Shared types and constants for the line segment clipper.
package lsc_pkg;

  // Window edges, tested left, right, bottom, top
  localparam int NUM_EDGES = 4;
  localparam int EDGE_LEFT = 0;
  localparam int EDGE_RIGHT = 1;
  localparam int EDGE_BOTTOM = 2;
  localparam int EDGE_TOP = 3;

  // Configuration register indexes
  localparam logic [1:0] REG_WINDOW_LEFT = 2'd0;
  localparam logic [1:0] REG_WINDOW_RIGHT = 2'd1;
  localparam logic [1:0] REG_WINDOW_BOTTOM = 2'd2;
  localparam logic [1:0] REG_WINDOW_TOP = 2'd3;

  // Reset value of the right and top edges: 1.0 in Q16.16
  localparam int WINDOW_ONE = 65536;

  // What one edge does to the parameter range
  typedef enum logic [1:0] {
    EK_NONE   = 2'd0,
    EK_REJECT = 2'd1,
    EK_ENTRY  = 2'd2,
    EK_EXIT   = 2'd3
  } edge_kind_t;

endpackage

FILE: src/line_segment_clipper.sv
// Liang-Barsky line segment clipper, fully pipelined.
// A segment may enter while others are in flight; the edge ratios run through a
// pipelined restoring divider, one quotient bit per stage, four lanes side by side.
// Reset (rst_n low, synchronous) clears all valid bits and loads the default window.
// The receiver cannot stall; busy is always low.
module line_segment_clipper #(
  parameter int COORD_WIDTH = 32,
  parameter int PARAM_FRAC_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_start_x,
  input  logic signed [COORD_WIDTH-1:0] in_start_y,
  input  logic signed [COORD_WIDTH-1:0] in_end_x,
  input  logic signed [COORD_WIDTH-1:0] in_end_y,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_addr,
  input  logic [COORD_WIDTH-1:0]        cfg_wdata,
  output logic                          out_valid,
  output logic                          out_accepted,
  output logic signed [COORD_WIDTH-1:0] out_clipped_start_x,
  output logic signed [COORD_WIDTH-1:0] out_clipped_start_y,
  output logic signed [COORD_WIDTH-1:0] out_clipped_end_x,
  output logic signed [COORD_WIDTH-1:0] out_clipped_end_y
);

  localparam int W = COORD_WIDTH;
  localparam int F = PARAM_FRAC_BITS;
  localparam int NE = lsc_pkg::NUM_EDGES;
  // stage 1 entry, 2 classify, 3..3+F divide, 4+F combine, 5+F multiply
  localparam int LAST = F + 5;
  localparam int SC = F + 4;
  localparam logic [F:0] T_ONE = {1'b1, {F{1'b0}}};
  localparam logic [F:0] T_ABOVE = {1'b1, {(F-1){1'b0}}, 1'b1};

  logic [W-1:0] win_l_r, win_r_r, win_b_r, win_t_r;

  logic [LAST:1] vld_r;
  logic signed [W-1:0] x0_r [1:LAST];
  logic signed [W-1:0] y0_r [1:LAST];
  logic signed [W-1:0] x1_r [1:LAST];
  logic signed [W-1:0] y1_r [1:LAST];

  logic signed [W:0] p1_r [NE];
  logic signed [W:0] q1_r [NE];

  logic [W:0] mdx_r [2:LAST];
  logic [W:0] mdy_r [2:LAST];
  logic [LAST:2] dxneg_r, dyneg_r;

  lsc_pkg::edge_kind_t kind2_r [NE];
  logic [W:0] n2_r [NE];
  logic [W:0] d2_r [NE];

  lsc_pkg::edge_kind_t kind_r [0:F][NE];
  logic [W:0] d_r [0:F][NE];
  logic [W:0] rem_r [0:F][NE];
  logic [F-1:0] quo_r [0:F][NE];
  logic gt_r [0:F][NE];
  logic eq_r [0:F][NE];

  logic [F:0] t0_r, t1_r;
  logic rej_r;
  logic [F:0] t0_nxt, t1_nxt;
  logic rej_nxt;

  logic ok_r;
  logic [W+1:0] prod_r [4];

  logic in_take;
  logic signed [W:0] sx0, sy0, sx1, sy1;

  assign busy = 1'b0;
  assign in_take = start & ~busy;

  // Hold the window registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_l_r <= '0;
      win_r_r <= W'(lsc_pkg::WINDOW_ONE);
      win_b_r <= '0;
      win_t_r <= W'(lsc_pkg::WINDOW_ONE);
    end else if (cfg_we) begin
      case (cfg_addr)
        lsc_pkg::REG_WINDOW_LEFT:   win_l_r <= cfg_wdata;
        lsc_pkg::REG_WINDOW_RIGHT:  win_r_r <= cfg_wdata;
        lsc_pkg::REG_WINDOW_BOTTOM: win_b_r <= cfg_wdata;
        lsc_pkg::REG_WINDOW_TOP:    win_t_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      out_valid <= 1'b0;
    end else begin
      vld_r <= {vld_r[LAST-1:1], in_take};
      out_valid <= vld_r[LAST];
    end
  end

  // Carry the input endpoints down the pipeline
  always_ff @(posedge clk) begin
    x0_r[1] <= in_start_x;
    y0_r[1] <= in_start_y;
    x1_r[1] <= in_end_x;
    y1_r[1] <= in_end_y;
    for (int s = 2; s <= LAST; s++) begin
      x0_r[s] <= x0_r[s-1];
      y0_r[s] <= y0_r[s-1];
      x1_r[s] <= x1_r[s-1];
      y1_r[s] <= y1_r[s-1];
    end
  end

  // Stage 1: direction and distance terms per edge
  assign sx0 = {in_start_x[W-1], in_start_x};
  assign sy0 = {in_start_y[W-1], in_start_y};
  assign sx1 = {in_end_x[W-1], in_end_x};
  assign sy1 = {in_end_y[W-1], in_end_y};

  always_ff @(posedge clk) begin
    p1_r[lsc_pkg::EDGE_LEFT]   <= sx0 - sx1;
    q1_r[lsc_pkg::EDGE_LEFT]   <= sx0 - $signed({win_l_r[W-1], win_l_r});
    p1_r[lsc_pkg::EDGE_RIGHT]  <= sx1 - sx0;
    q1_r[lsc_pkg::EDGE_RIGHT]  <= $signed({win_r_r[W-1], win_r_r}) - sx0;
    p1_r[lsc_pkg::EDGE_BOTTOM] <= sy0 - sy1;
    q1_r[lsc_pkg::EDGE_BOTTOM] <= sy0 - $signed({win_b_r[W-1], win_b_r});
    p1_r[lsc_pkg::EDGE_TOP]    <= sy1 - sy0;
    q1_r[lsc_pkg::EDGE_TOP]    <= $signed({win_t_r[W-1], win_t_r}) - sy0;
  end

  // Stage 2: classify each edge and take magnitudes; carry the differences
  always_ff @(posedge clk) begin
    for (int e = 0; e < NE; e++) begin
      if (p1_r[e] < 0) begin
        kind2_r[e] <= (q1_r[e] > 0) ? lsc_pkg::EK_NONE : lsc_pkg::EK_ENTRY;
        n2_r[e] <= (W+1)'(0) - q1_r[e];
        d2_r[e] <= (W+1)'(0) - p1_r[e];
      end else if (p1_r[e] > 0) begin
        kind2_r[e] <= (q1_r[e] < 0) ? lsc_pkg::EK_REJECT : lsc_pkg::EK_EXIT;
        n2_r[e] <= q1_r[e];
        d2_r[e] <= p1_r[e];
      end else begin
        kind2_r[e] <= (q1_r[e] < 0) ? lsc_pkg::EK_REJECT : lsc_pkg::EK_NONE;
        n2_r[e] <= q1_r[e];
        d2_r[e] <= p1_r[e];
      end
    end
    dxneg_r[2] <= p1_r[lsc_pkg::EDGE_RIGHT][W];
    dyneg_r[2] <= p1_r[lsc_pkg::EDGE_TOP][W];
    mdx_r[2] <= p1_r[lsc_pkg::EDGE_RIGHT][W] ? (W+1)'(0) - p1_r[lsc_pkg::EDGE_RIGHT]
                                             : p1_r[lsc_pkg::EDGE_RIGHT];
    mdy_r[2] <= p1_r[lsc_pkg::EDGE_TOP][W] ? (W+1)'(0) - p1_r[lsc_pkg::EDGE_TOP]
                                           : p1_r[lsc_pkg::EDGE_TOP];
    for (int s = 3; s <= LAST; s++) begin
      mdx_r[s] <= mdx_r[s-1];
      mdy_r[s] <= mdy_r[s-1];
    end
    dxneg_r[LAST:3] <= dxneg_r[LAST-1:2];
    dyneg_r[LAST:3] <= dyneg_r[LAST-1:2];
  end

  // Stage 3: saturation checks, load the divider
  always_ff @(posedge clk) begin
    for (int e = 0; e < NE; e++) begin
      kind_r[0][e] <= kind2_r[e];
      d_r[0][e] <= d2_r[e];
      rem_r[0][e] <= n2_r[e];
      quo_r[0][e] <= '0;
      gt_r[0][e] <= n2_r[e] > d2_r[e];
      eq_r[0][e] <= n2_r[e] == d2_r[e];
    end
  end

  // Divider: one quotient bit per stage in every lane
  for (genvar k = 1; k <= F; k++) begin : g_div
    for (genvar e = 0; e < NE; e++) begin : g_lane
      logic [W+1:0] rem2;
      logic take;
      assign rem2 = {rem_r[k-1][e], 1'b0};
      assign take = rem2 >= {1'b0, d_r[k-1][e]};
      always_ff @(posedge clk) begin
        kind_r[k][e] <= kind_r[k-1][e];
        d_r[k][e] <= d_r[k-1][e];
        gt_r[k][e] <= gt_r[k-1][e];
        eq_r[k][e] <= eq_r[k-1][e];
        rem_r[k][e] <= take ? (W+1)'(rem2 - {1'b0, d_r[k-1][e]}) : rem2[W:0];
        quo_r[k][e] <= {quo_r[k-1][e][F-2:0], take};
      end
    end
  end

  // Combine: latest entry, earliest exit, any direct reject
  always_comb begin
    logic [F:0] r;
    t0_nxt = '0;
    t1_nxt = T_ONE;
    rej_nxt = 1'b0;
    for (int e = 0; e < NE; e++) begin
      r = gt_r[F][e] ? T_ABOVE : (eq_r[F][e] ? T_ONE : {1'b0, quo_r[F][e]});
      if (kind_r[F][e] == lsc_pkg::EK_REJECT) rej_nxt = 1'b1;
      if (kind_r[F][e] == lsc_pkg::EK_ENTRY && r > t0_nxt) t0_nxt = r;
      if (kind_r[F][e] == lsc_pkg::EK_EXIT && r < t1_nxt) t1_nxt = r;
    end
  end

  always_ff @(posedge clk) begin
    t0_r <= t0_nxt;
    t1_r <= t1_nxt;
    rej_r <= rej_nxt;
  end

  // Multiply: scale the differences by the clipped parameters
  always_ff @(posedge clk) begin
    ok_r <= ~rej_r && (t0_r <= t1_r);
    prod_r[0] <= (W+2)'(({{(F+1){1'b0}}, mdx_r[SC]} * {{(W+1){1'b0}}, t0_r}) >> F);
    prod_r[1] <= (W+2)'(({{(F+1){1'b0}}, mdy_r[SC]} * {{(W+1){1'b0}}, t0_r}) >> F);
    prod_r[2] <= (W+2)'(({{(F+1){1'b0}}, mdx_r[SC]} * {{(W+1){1'b0}}, t1_r}) >> F);
    prod_r[3] <= (W+2)'(({{(F+1){1'b0}}, mdy_r[SC]} * {{(W+1){1'b0}}, t1_r}) >> F);
  end

  // Output: move endpoints from the start point, or pass the input through
  always_ff @(posedge clk) begin
    logic [W+1:0] bx, by;
    bx = {{2{x0_r[LAST][W-1]}}, x0_r[LAST]};
    by = {{2{y0_r[LAST][W-1]}}, y0_r[LAST]};
    out_accepted <= ok_r;
    if (ok_r) begin
      out_clipped_start_x <= W'(dxneg_r[LAST] ? bx - prod_r[0] : bx + prod_r[0]);
      out_clipped_start_y <= W'(dyneg_r[LAST] ? by - prod_r[1] : by + prod_r[1]);
      out_clipped_end_x   <= W'(dxneg_r[LAST] ? bx - prod_r[2] : bx + prod_r[2]);
      out_clipped_end_y   <= W'(dyneg_r[LAST] ? by - prod_r[3] : by + prod_r[3]);
    end else begin
      out_clipped_start_x <= x0_r[LAST];
      out_clipped_start_y <= y0_r[LAST];
      out_clipped_end_x   <= x1_r[LAST];
      out_clipped_end_y   <= y1_r[LAST];
    end
  end

endmodule

FILE: sim/tb_line_segment_clipper.sv
// Self-checking testbench for the line segment clipper: directed and random segments.
`timescale 1ns / 1ps

module tb_line_segment_clipper;

  localparam int CW = 32;
  localparam int PF = 24;
  localparam int LAT = PF + 6;
  localparam longint unsigned T_ONE = 64'd1 << PF;

  typedef logic signed [CW-1:0] coord_t;

  typedef struct {
    coord_t sx, sy, ex, ey;
  } segment_t;

  typedef struct {
    logic   acc;
    coord_t sx, sy, ex, ey;
  } clip_t;

  // Scoreboard: predicts the clip of each accepted segment and checks results
  class clip_scoreboard;
    coord_t win_l, win_r, win_b, win_t;
    clip_t  expected_clips[$];
    int     errors;

    function new();
      win_l = 0;
      win_r = lsc_pkg::WINDOW_ONE;
      win_b = 0;
      win_t = lsc_pkg::WINDOW_ONE;
      errors = 0;
    endfunction

    function void set_reg(logic [1:0] idx, coord_t val);
      case (idx)
        lsc_pkg::REG_WINDOW_LEFT:   win_l = val;
        lsc_pkg::REG_WINDOW_RIGHT:  win_r = val;
        lsc_pkg::REG_WINDOW_BOTTOM: win_b = val;
        default:                    win_t = val;
      endcase
    endfunction

    // Q1.F quotient of n/d, saturated one LSB above 1.0
    function longint unsigned divide(longint unsigned n, longint unsigned d);
      longint unsigned rem, quo;
      rem = n;
      quo = 0;
      if (n > d) return T_ONE + 1;
      if (n == d) return T_ONE;
      for (int i = 0; i < PF; i++) begin
        rem = rem << 1;
        quo = quo << 1;
        if (rem >= d) begin
          rem = rem - d;
          quo = quo | 1;
        end
      end
      return quo;
    endfunction

    // Narrow [t0, t1] by one edge; return 0 on reject
    function bit narrow(longint p, longint q, inout longint unsigned t0,
                        inout longint unsigned t1);
      longint unsigned r;
      if (p < 0) begin
        if (q > 0) return 1;
        r = divide(-q, -p);
        if (r > t1) return 0;
        if (r > t0) t0 = r;
        return 1;
      end
      if (p > 0) begin
        if (q < 0) return 0;
        r = divide(q, p);
        if (r < t0) return 0;
        if (r < t1) t1 = r;
        return 1;
      end
      return q >= 0;
    endfunction

    // trunc(t * d) toward zero
    function longint offset(longint d, longint unsigned t);
      longint unsigned m, prod;
      m = (d < 0) ? -d : d;
      if (t >= T_ONE) prod = m;
      else prod = (m >> PF) * t + (((m & (T_ONE - 1)) * t) >> PF);
      return (d < 0) ? -longint'(prod) : longint'(prod);
    endfunction

    // Note an accepted segment and queue its predicted clip
    function void note(segment_t s);
      longint x0, y0, x1, y1, dx, dy;
      longint unsigned t0, t1;
      bit ok;
      clip_t c;
      x0 = s.sx; y0 = s.sy; x1 = s.ex; y1 = s.ey;
      dx = x1 - x0;
      dy = y1 - y0;
      t0 = 0;
      t1 = T_ONE;
      ok = narrow(-dx, x0 - longint'(win_l), t0, t1);
      if (ok) ok = narrow(dx, longint'(win_r) - x0, t0, t1);
      if (ok) ok = narrow(-dy, y0 - longint'(win_b), t0, t1);
      if (ok) ok = narrow(dy, longint'(win_t) - y0, t0, t1);
      c.acc = ok;
      c.sx = s.sx; c.sy = s.sy; c.ex = s.ex; c.ey = s.ey;
      if (ok && t1 < T_ONE) begin
        c.ex = coord_t'(x0 + offset(dx, t1));
        c.ey = coord_t'(y0 + offset(dy, t1));
      end
      if (ok && t0 > 0) begin
        c.sx = coord_t'(x0 + offset(dx, t0));
        c.sy = coord_t'(y0 + offset(dy, t0));
      end
      expected_clips.push_back(c);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    // Check one result against the oldest predicted clip
    task check(clip_t got);
      clip_t want;
      if (expected_clips.size() == 0) begin
        report("unexpected result", 1, 0);
        return;
      end
      want = expected_clips.pop_front();
      if (got.acc !== want.acc) report("accepted", got.acc, want.acc);
      if (got.sx !== want.sx) report("clipped_start_x", got.sx, want.sx);
      if (got.sy !== want.sy) report("clipped_start_y", got.sy, want.sy);
      if (got.ex !== want.ex) report("clipped_end_x", got.ex, want.ex);
      if (got.ey !== want.ey) report("clipped_end_y", got.ey, want.ey);
    endtask
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  coord_t in_start_x = 0, in_start_y = 0, in_end_x = 0, in_end_y = 0;
  logic cfg_we = 0;
  logic [1:0] cfg_addr = '0;
  logic [CW-1:0] cfg_wdata = '0;
  logic out_valid, out_accepted;
  coord_t out_clipped_start_x, out_clipped_start_y, out_clipped_end_x, out_clipped_end_y;

  clip_scoreboard sb = new();
  int sender_idle_pct;

  line_segment_clipper #(.COORD_WIDTH(CW), .PARAM_FRAC_BITS(PF)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_start_x(in_start_x), .in_start_y(in_start_y),
    .in_end_x(in_end_x), .in_end_y(in_end_y),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
    .out_valid(out_valid), .out_accepted(out_accepted),
    .out_clipped_start_x(out_clipped_start_x), .out_clipped_start_y(out_clipped_start_y),
    .out_clipped_end_x(out_clipped_end_x), .out_clipped_end_y(out_clipped_end_y)
  );

  always #2 clk = ~clk;

  // Sample each result strobe
  always @(posedge clk) begin
    clip_t got;
    if (rst_n && out_valid) begin
      got.acc = out_accepted;
      got.sx = out_clipped_start_x;
      got.sy = out_clipped_start_y;
      got.ex = out_clipped_end_x;
      got.ey = out_clipped_end_y;
      sb.check(got);
    end
  end

  // Drive one item after a random gap; hold until accepted
  task send(segment_t s);
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 0;
    end
    @(negedge clk);
    start <= 1;
    in_start_x <= s.sx;
    in_start_y <= s.sy;
    in_end_x <= s.ex;
    in_end_y <= s.ey;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note(s);
  endtask

  // Drop start, drain all results, then let the pipeline settle
  task drain();
    @(negedge clk);
    start <= 0;
    while (sb.expected_clips.size() > 0) @(posedge clk);
    repeat (LAT + 4) @(posedge clk);
  endtask

  task cfg_write(logic [1:0] idx, coord_t val);
    @(negedge clk);
    cfg_we <= 1;
    cfg_addr <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
  endtask

  task set_window(coord_t l, coord_t r, coord_t b, coord_t t);
    cfg_write(lsc_pkg::REG_WINDOW_LEFT, l);
    cfg_write(lsc_pkg::REG_WINDOW_RIGHT, r);
    cfg_write(lsc_pkg::REG_WINDOW_BOTTOM, b);
    cfg_write(lsc_pkg::REG_WINDOW_TOP, t);
  endtask

  function automatic coord_t clamp(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return coord_t'(v);
  endfunction

  // Pick a coordinate: anywhere, on or next to an edge, or near the window
  function automatic coord_t pick(coord_t lo, coord_t hi);
    longint a, b, span;
    a = (lo < hi) ? lo : hi;
    b = (lo < hi) ? hi : lo;
    span = b - a;
    case ($urandom_range(9))
      0, 1: return coord_t'($urandom);
      2: return lo;
      3: return hi;
      4: return clamp(longint'($urandom_range(1) ? lo : hi) + $urandom_range(2) - 1);
      default:
        return clamp(a - span / 4 +
                     longint'({$urandom, $urandom} % (span + span / 2 + 1)));
    endcase
  endfunction

  function automatic segment_t rand_segment();
    segment_t s;
    s.sx = pick(sb.win_l, sb.win_r);
    s.sy = pick(sb.win_b, sb.win_t);
    s.ex = pick(sb.win_l, sb.win_r);
    s.ey = pick(sb.win_b, sb.win_t);
    case ($urandom_range(9))
      0: begin s.ex = s.sx; s.ey = s.sy; end
      1: s.ex = s.sx;
      2: s.ey = s.sy;
      default: ;
    endcase
    return s;
  endfunction

  function automatic segment_t seg(coord_t a, coord_t b, coord_t c, coord_t d);
    segment_t s;
    s.sx = a; s.sy = b; s.ex = c; s.ey = d;
    return s;
  endfunction

  initial begin
    segment_t directed[$];
    coord_t l, b;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    repeat (2) @(posedge clk);

    // Directed segments against the reset window [0, 1.0]^2
    sender_idle_pct = 0;
    directed.push_back(seg(32'sh4000, 32'sh4000, 32'shc000, 32'shc000));
    directed.push_back(seg(-32'sh8000, 32'sh8000, 32'sh18000, 32'sh8000));
    directed.push_back(seg(32'sh8000, -32'sh8000, 32'sh8000, 32'sh18000));
    directed.push_back(seg(-32'sh10000, 32'sh8000, -32'sh8000, 32'sh9000));
    directed.push_back(seg(32'sh20000, 32'sh8000, 32'sh30000, 32'sh9000));
    directed.push_back(seg(32'sh8000, -32'sh8000, 32'sh9000, -32'sh1000));
    directed.push_back(seg(32'sh8000, 32'sh20000, 32'sh9000, 32'sh30000));
    directed.push_back(seg(0, 0, 32'sh10000, 32'sh10000));
    directed.push_back(seg(32'sh10000, 0, 32'sh10000, 32'sh10000));
    directed.push_back(seg(-32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000));
    directed.push_back(seg(32'sh8000, 32'sh8000, 32'sh8000, 32'sh8000));
    directed.push_back(seg(32'sh20000, 32'sh8000, 32'sh20000, 32'sh8000));
    directed.push_back(seg(32'sh10000, 32'sh10000, 32'sh10000, 32'sh10000));
    directed.push_back(seg(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff));
    directed.push_back(seg(32'sh7fffffff, 32'sh80000000, 32'sh80000000, 32'sh7fffffff));
    directed.push_back(seg(32'sh80000000, 32'sh8000, 32'sh7fffffff, 32'sh8000));
    directed.push_back(seg(-32'sh8000, -32'sh8000, 32'sh8000, 32'sh30000));
    directed.push_back(seg(32'sh18000, 32'sh4000, -32'sh4000, 32'sh18000));
    directed.push_back(seg(-32'sh1, 32'sh8000, 32'sh10001, 32'sh8001));
    foreach (directed[i]) send(directed[i]);
    drain();

    // Random phases, one window setting each
    for (int ph = 0; ph < 9; ph++) begin
      sender_idle_pct = (ph < 3) ? 21 : (ph < 6) ? 46 : 0;
      case (ph)
        0: set_window(0, lsc_pkg::WINDOW_ONE, 0, lsc_pkg::WINDOW_ONE);
        1: set_window(32'sh80000000, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff);
        2: set_window(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000);
        3: set_window(-32'sh30000, 32'sh50000, -32'sh20000, 32'sh10000);
        4: set_window(32'sh1234, 32'sh1234, -32'sh10000, 32'sh10000);
        5: set_window(32'sh20000, 32'sh10000, 0, lsc_pkg::WINDOW_ONE);
        default: begin
          l = coord_t'($urandom);
          b = coord_t'($urandom);
          set_window(l, clamp(longint'(l) + $urandom_range(32'h00ffffff)),
                     b, clamp(longint'(b) + $urandom_range(32'h00ffffff)));
        end
      endcase
      repeat (204) send(rand_segment());
      drain();
    end

    if (sb.errors == 0 && sb.expected_clips.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Hard stop on hang
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

endmodule
